### design/pccr_pkg.sv
// Shared types, widths and helpers of the circle collision resolver.
package pccr_pkg;

    localparam int MAX_ENTITIES_DEF = 64;

    localparam int POS_W    = 24;           // Q15.8 position and velocity
    localparam int RAD_W    = 16;           // Q8.8 radius
    localparam int CNT_W    = 6;            // contact counter
    localparam int DIFF_W   = POS_W + 1;    // coordinate difference
    localparam int RSUM_W   = RAD_W + 1;    // radius sum
    localparam int D2_W     = 2 * DIFF_W;   // squared distance
    localparam int M2_W     = 2 * RSUM_W;   // squared radius sum
    localparam int ROOT_W   = DIFF_W;       // floor(sqrt(d2))
    localparam int NUM_W    = DIFF_W + RSUM_W;  // dividend of the separation divider
    localparam int DEN_W    = ROOT_W + 1;   // divisor (twice the distance)
    localparam int SUM_W    = NUM_W + 2;    // position plus or minus separation
    localparam int IN_DATA_W  = 4 * POS_W + RAD_W;
    localparam int OUT_BITS   = 4 * POS_W + CNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // damping: |v| * 9, then divide by 10 through a reciprocal multiply;
    // ceil(2^30 / 10) is exact for every product below 2^27
    localparam int DAMP_P_W    = POS_W + 4;
    localparam int DAMP_R_W    = 27;
    localparam int DAMP_PROD_W = DAMP_P_W + DAMP_R_W;
    localparam int DAMP_SHIFT  = 30;

    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;
    localparam logic [DAMP_R_W-1:0] DAMP_RECIP = 27'd107374183;
    localparam logic [3:0]          DAMP_MUL   = 4'd9;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic        [RAD_W-1:0] radius;
        logic                    vehicle;
        logic        [CNT_W-1:0] contacts;
    } t_body;

    typedef enum logic [4:0] {
        S_LOAD, S_RDA, S_LATA, S_RDB, S_LATB, S_DIFF, S_SQX, S_SQY, S_MSQ, S_CMP,
        S_SQGO, S_SQW, S_OVL, S_SMUL, S_SDGO, S_SDW, S_SAPP,
        S_DMUL, S_DDGO, S_DAPP, S_VCOM, S_WRA, S_WRB,
        S_ERD, S_ELD, S_EOUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_RD, OP_LATA, OP_LATB, OP_DIFF, OP_SQX, OP_SQY, OP_MSQ,
        OP_CMP, OP_SQ_GO, OP_OVL, OP_SMUL, OP_SDIV_GO, OP_SAPP,
        OP_DMUL, OP_DDIV_GO, OP_DAPP, OP_VCOM, OP_WRA, OP_WRB, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sub;    // axis, damping slot, or last flag for OP_OUT
    } t_cmd;

    typedef struct packed {
        logic collide;
        logic coincident;
        logic both_veh;
        logic unit_done;
    } t_stat;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-POS_W:0] top;
        top = v[SUM_W-1:POS_W-1];
        if (top == '0 || top == '1) begin
            return v[POS_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

endpackage

### design/pairwise_circle_collision_resolve_unit.sv
// Top level of the pairwise circle collision resolver.
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata: body, tuser: vehicle, tlast
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata: body + contacts, tuser: hit
//
// Loading accepts one body request per cycle. The request with tlast starts the pair
// sweep over all i<j; a pair that overlaps adds a square root wait, two divider
// waits (one per axis) and glue steps. Both vehicles add four reciprocal-multiply
// dampings plus the swap; a coincident pair skips the push. Each result is read,
// latched into the output register and offered until taken. Reset (synchronous,
// active low) empties the frame; the body memory needs no clearing. Input is
// stalled from the last request until the final result of the frame has been taken.
module pairwise_circle_collision_resolve_unit #(
    parameter int MAX_ENTITIES = pccr_pkg::MAX_ENTITIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, radius
    input  logic [pccr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // is_vehicle
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_pos_x, out_pos_y, out_vel_x, out_vel_y, contact_count, zero pad
    output logic [pccr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // hit
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    localparam int AW = $clog2(MAX_ENTITIES);
    localparam int PW = pccr_pkg::POS_W;

    pccr_pkg::t_cmd  w_cmd;
    pccr_pkg::t_stat w_stat;
    pccr_pkg::t_body w_in, w_out;
    logic [AW-1:0]   w_addr;

    // unpack the request; contacts start from zero at load
    assign w_in.pos_x    = s_axis_tdata[PW-1:0];
    assign w_in.pos_y    = s_axis_tdata[2*PW-1:PW];
    assign w_in.vel_x    = s_axis_tdata[3*PW-1:2*PW];
    assign w_in.vel_y    = s_axis_tdata[4*PW-1:3*PW];
    assign w_in.radius   = s_axis_tdata[4*PW+pccr_pkg::RAD_W-1:4*PW];
    assign w_in.vehicle  = s_axis_tuser;
    assign w_in.contacts = '0;

    pccr_ctrl #(.MAX_ENTITIES(MAX_ENTITIES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_addr      (w_addr)
    );

    pccr_dp #(.MAX_ENTITIES(MAX_ENTITIES)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_addr  (w_addr),
        .i_body  (w_in),
        .o_stat  (w_stat),
        .o_body  (w_out),
        .o_last  (m_axis_tlast)
    );

    // pack the result; hit is any nonzero contact count
    assign m_axis_tdata = pccr_pkg::OUT_DATA_W'({w_out.contacts, w_out.vel_y, w_out.vel_x,
                                                  w_out.pos_y, w_out.pos_x});
    assign m_axis_tuser = (w_out.contacts != '0);

    // one frame at a time: never take a body while a result is offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // the closing body stops intake until the frame is emitted
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("intake not held after closing body");

    // taking the final result reopens intake
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("intake not reopened after final result");

    // a result that carries contacts always reports a hit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[4*PW+pccr_pkg::CNT_W-1:4*PW] != '0)))
        else $error("hit flag disagrees with contact count");
endmodule

### design/pccr_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module pccr_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pccr_pkg::D2_W-1:0]     i_val,
    output logic [pccr_pkg::ROOT_W-1:0]   o_root,
    output logic                          o_done
);
    localparam int W = pccr_pkg::D2_W;

    logic [W-1:0] r_n, r_res, r_bit;
    logic         r_busy, r_done;
    logic [W-1:0] w_sum;

    assign w_sum = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_val;
            r_res <= '0;
            r_bit <= {2'b01, {(W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_n >= w_sum) begin
                r_n   <= r_n - w_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[pccr_pkg::ROOT_W-1:0];
    assign o_done = r_done;
endmodule

### design/pccr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module pccr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pccr_pkg::NUM_W-1:0]   i_num,
    input  logic [pccr_pkg::DEN_W-1:0]   i_den,
    output logic [pccr_pkg::NUM_W-1:0]   o_quot,
    output logic                         o_done
);
    localparam int NW = pccr_pkg::NUM_W;
    localparam int DW = pccr_pkg::DEN_W;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem, r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   w_try;
    logic          w_ge;

    assign w_try = {r_rem, r_q[NW-1]};
    assign w_ge  = w_try >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CW'(NW - 1);
        end else if (r_busy) begin
            r_rem <= w_ge ? DW'(w_try - {1'b0, r_den}) : w_try[DW-1:0];
            r_q   <= {r_q[NW-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;
endmodule

### design/pccr_dp.sv
// Datapath: body memory, pair registers, arithmetic and output holding register.
module pccr_dp #(
    parameter int MAX_ENTITIES = pccr_pkg::MAX_ENTITIES_DEF,
    localparam int AW = $clog2(MAX_ENTITIES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pccr_pkg::t_cmd        i_cmd,
    input  logic [AW-1:0]         i_addr,
    input  pccr_pkg::t_body       i_body,
    output pccr_pkg::t_stat       o_stat,
    output pccr_pkg::t_body       o_body,
    output logic                  o_last
);
    localparam int PW = pccr_pkg::POS_W;

    pccr_pkg::t_body r_mem [MAX_ENTITIES];
    pccr_pkg::t_body r_rdata, r_a, r_b, r_out, w_wdata;
    logic                                r_out_last;
    logic signed [pccr_pkg::DIFF_W-1:0]  r_dx, r_dy;
    logic [pccr_pkg::RSUM_W-1:0]         r_m, r_ovl;
    logic [pccr_pkg::D2_W-1:0]           r_sq, r_d2;
    logic [pccr_pkg::M2_W-1:0]           r_m2;
    logic [pccr_pkg::DEN_W-1:0]          r_den2;
    logic [pccr_pkg::NUM_W-1:0]          r_prod;
    logic                                r_neg;
    logic [PW-1:0]                       r_dmag;
    logic signed [PW-1:0]                r_dv [4];

    logic                                w_wr, w_sq_done, w_div_done, w_div_go;
    logic [pccr_pkg::ROOT_W-1:0]         w_root;
    logic [pccr_pkg::NUM_W-1:0]          w_quot;
    logic signed [pccr_pkg::D2_W-1:0]    w_sqx, w_sqy;
    logic signed [pccr_pkg::DIFF_W-1:0]  w_d;
    logic [pccr_pkg::DIFF_W-1:0]         w_mag;
    logic signed [PW-1:0]                w_v;
    logic [PW-1:0]                       w_vmag;
    logic signed [pccr_pkg::SUM_W-1:0]   w_sep, w_qs;
    logic signed [PW-1:0]                w_dq;
    logic [pccr_pkg::DAMP_PROD_W-1:0]    w_dprod;
    logic                                w_collide;

    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;
    assign w_d   = i_cmd.sub[0] ? r_dy : r_dx;
    assign w_mag = w_d[pccr_pkg::DIFF_W-1] ? pccr_pkg::DIFF_W'(-w_d) : w_d;
    always_comb begin
        unique case (i_cmd.sub)
            2'd0:    w_v = r_b.vel_x;
            2'd1:    w_v = r_b.vel_y;
            2'd2:    w_v = r_a.vel_x;
            default: w_v = r_a.vel_y;
        endcase
    end
    assign w_vmag  = w_v[PW-1] ? PW'(-w_v) : w_v;
    assign w_qs    = $signed({2'b00, w_quot});
    assign w_sep   = r_neg ? -w_qs : w_qs;
    assign w_dprod = r_prod[pccr_pkg::DAMP_P_W-1:0] * pccr_pkg::DAMP_RECIP;
    assign w_dq    = r_neg ? -$signed(r_dmag) : $signed(r_dmag);
    assign w_collide = r_d2 < pccr_pkg::D2_W'(r_m2);

    assign w_wr = (i_cmd.op == pccr_pkg::OP_LOAD) || (i_cmd.op == pccr_pkg::OP_WRA) ||
                  (i_cmd.op == pccr_pkg::OP_WRB);
    always_comb begin
        priority case (i_cmd.op)
            pccr_pkg::OP_WRA: w_wdata = r_a;
            pccr_pkg::OP_WRB: w_wdata = r_b;
            default: begin
                w_wdata          = i_body;
                w_wdata.contacts = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[i_addr] <= w_wdata;
        end
        if (i_cmd.op == pccr_pkg::OP_RD) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            pccr_pkg::OP_LATA: r_a <= r_rdata;
            pccr_pkg::OP_LATB: r_b <= r_rdata;
            pccr_pkg::OP_DIFF: begin
                r_dx <= pccr_pkg::DIFF_W'(r_b.pos_x) - pccr_pkg::DIFF_W'(r_a.pos_x);
                r_dy <= pccr_pkg::DIFF_W'(r_b.pos_y) - pccr_pkg::DIFF_W'(r_a.pos_y);
                r_m  <= pccr_pkg::RSUM_W'(r_a.radius) + pccr_pkg::RSUM_W'(r_b.radius);
            end
            pccr_pkg::OP_SQX: r_sq <= w_sqx;
            pccr_pkg::OP_SQY: r_d2 <= r_sq + w_sqy;
            pccr_pkg::OP_MSQ: r_m2 <= r_m * r_m;
            pccr_pkg::OP_CMP: begin
                if (w_collide) begin
                    if (r_a.contacts != pccr_pkg::CNT_MAX) r_a.contacts <= r_a.contacts + 1'b1;
                    if (r_b.contacts != pccr_pkg::CNT_MAX) r_b.contacts <= r_b.contacts + 1'b1;
                end
            end
            pccr_pkg::OP_OVL: begin
                r_ovl  <= r_m - w_root[pccr_pkg::RSUM_W-1:0];
                r_den2 <= {w_root, 1'b0};
            end
            pccr_pkg::OP_SMUL: begin
                r_prod <= w_mag * r_ovl;
                r_neg  <= w_d[pccr_pkg::DIFF_W-1];
            end
            pccr_pkg::OP_SAPP: begin
                if (i_cmd.sub[0]) begin
                    r_a.pos_y <= pccr_pkg::sat_pos(pccr_pkg::SUM_W'(r_a.pos_y) - w_sep);
                    r_b.pos_y <= pccr_pkg::sat_pos(pccr_pkg::SUM_W'(r_b.pos_y) + w_sep);
                end else begin
                    r_a.pos_x <= pccr_pkg::sat_pos(pccr_pkg::SUM_W'(r_a.pos_x) - w_sep);
                    r_b.pos_x <= pccr_pkg::sat_pos(pccr_pkg::SUM_W'(r_b.pos_x) + w_sep);
                end
            end
            pccr_pkg::OP_DMUL: begin
                r_prod <= pccr_pkg::NUM_W'(w_vmag * pccr_pkg::DAMP_MUL);
                r_neg  <= w_v[PW-1];
            end
            pccr_pkg::OP_DDIV_GO: r_dmag <= w_dprod[pccr_pkg::DAMP_SHIFT +: PW];
            pccr_pkg::OP_DAPP: r_dv[i_cmd.sub] <= w_dq;
            pccr_pkg::OP_VCOM: begin
                r_a.vel_x <= r_dv[0];
                r_a.vel_y <= r_dv[1];
                r_b.vel_x <= r_dv[2];
                r_b.vel_y <= r_dv[3];
            end
            pccr_pkg::OP_OUT: begin
                r_out      <= r_rdata;
                r_out_last <= i_cmd.sub[0];
            end
            default: ;
        endcase
    end

    assign w_div_go = (i_cmd.op == pccr_pkg::OP_SDIV_GO);

    pccr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == pccr_pkg::OP_SQ_GO),
        .i_val   (r_d2),
        .o_root  (w_root),
        .o_done  (w_sq_done)
    );

    pccr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (r_prod),
        .i_den   (r_den2),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    assign o_stat.collide    = w_collide;
    assign o_stat.coincident = (r_d2 == '0);
    assign o_stat.both_veh   = r_a.vehicle & r_b.vehicle;
    assign o_stat.unit_done  = w_sq_done | w_div_done;
    assign o_body = r_out;
    assign o_last = r_out_last;
endmodule

### design/pccr_ctrl.sv
// Controller: load, pair sweep and emit sequencing.
module pccr_ctrl #(
    parameter int MAX_ENTITIES = pccr_pkg::MAX_ENTITIES_DEF,
    localparam int AW = $clog2(MAX_ENTITIES),
    localparam int CW = $clog2(MAX_ENTITIES + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  pccr_pkg::t_stat i_stat,
    output pccr_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]   o_addr
);
    pccr_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_i, n_i, r_j, n_j, r_e, n_e;
    logic [1:0]       r_sub, n_sub;
    logic             w_full, w_emit_last;
    logic [CW-1:0]    w_cnt_after;

    assign w_full      = (r_cnt == CW'(MAX_ENTITIES));
    assign w_cnt_after = w_full ? r_cnt : r_cnt + 1'b1;
    assign w_emit_last = (CW'(r_e) + 1'b1 == r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pccr_pkg::S_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_e     <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_e     <= n_e;
            r_sub   <= n_sub;
        end
    end

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_e     = r_e;
        n_sub   = r_sub;
        unique case (r_state)
            pccr_pkg::S_LOAD: begin
                if (i_in_valid) begin
                    n_cnt = w_cnt_after;
                    if (i_in_last) begin
                        n_i = '0;
                        n_j = AW'(1);
                        n_e = '0;
                        n_state = (w_cnt_after >= CW'(2)) ? pccr_pkg::S_RDA : pccr_pkg::S_ERD;
                    end
                end
            end
            pccr_pkg::S_RDA:  n_state = pccr_pkg::S_LATA;
            pccr_pkg::S_LATA: n_state = pccr_pkg::S_RDB;
            pccr_pkg::S_RDB:  n_state = pccr_pkg::S_LATB;
            pccr_pkg::S_LATB: n_state = pccr_pkg::S_DIFF;
            pccr_pkg::S_DIFF: n_state = pccr_pkg::S_SQX;
            pccr_pkg::S_SQX:  n_state = pccr_pkg::S_SQY;
            pccr_pkg::S_SQY:  n_state = pccr_pkg::S_MSQ;
            pccr_pkg::S_MSQ:  n_state = pccr_pkg::S_CMP;
            pccr_pkg::S_CMP: begin
                n_sub = '0;
                priority if (!i_stat.collide) begin
                    n_state = pccr_pkg::S_WRB;  // nothing changed; skip to pair advance
                end else if (!i_stat.coincident) begin
                    n_state = pccr_pkg::S_SQGO;
                end else if (i_stat.both_veh) begin
                    n_state = pccr_pkg::S_DMUL;
                end else begin
                    n_state = pccr_pkg::S_WRA;
                end
            end
            pccr_pkg::S_SQGO: n_state = pccr_pkg::S_SQW;
            pccr_pkg::S_SQW:  if (i_stat.unit_done) n_state = pccr_pkg::S_OVL;
            pccr_pkg::S_OVL:  n_state = pccr_pkg::S_SMUL;
            pccr_pkg::S_SMUL: n_state = pccr_pkg::S_SDGO;
            pccr_pkg::S_SDGO: n_state = pccr_pkg::S_SDW;
            pccr_pkg::S_SDW:  if (i_stat.unit_done) n_state = pccr_pkg::S_SAPP;
            pccr_pkg::S_SAPP: begin
                if (r_sub == 2'd0) begin
                    n_sub   = 2'd1;
                    n_state = pccr_pkg::S_SMUL;
                end else begin
                    n_sub   = 2'd0;
                    n_state = i_stat.both_veh ? pccr_pkg::S_DMUL : pccr_pkg::S_WRA;
                end
            end
            pccr_pkg::S_DMUL: n_state = pccr_pkg::S_DDGO;
            pccr_pkg::S_DDGO: n_state = pccr_pkg::S_DAPP;
            pccr_pkg::S_DAPP: begin
                n_sub   = r_sub + 1'b1;
                n_state = (r_sub == 2'd3) ? pccr_pkg::S_VCOM : pccr_pkg::S_DMUL;
            end
            pccr_pkg::S_VCOM: n_state = pccr_pkg::S_WRA;
            pccr_pkg::S_WRA:  n_state = pccr_pkg::S_WRB;
            pccr_pkg::S_WRB: begin
                // the not-colliding path also ends here, harmlessly rewriting j
                priority if (CW'(r_j) + 1'b1 < r_cnt) begin
                    n_j     = r_j + 1'b1;
                    n_state = pccr_pkg::S_RDA;
                end else if (CW'(r_i) + CW'(2) < r_cnt) begin
                    n_i     = r_i + 1'b1;
                    n_j     = r_i + AW'(2);
                    n_state = pccr_pkg::S_RDA;
                end else begin
                    n_e     = '0;
                    n_state = pccr_pkg::S_ERD;
                end
            end
            pccr_pkg::S_ERD:  n_state = pccr_pkg::S_ELD;
            pccr_pkg::S_ELD:  n_state = pccr_pkg::S_EOUT;
            pccr_pkg::S_EOUT: begin
                if (i_out_ready) begin
                    if (w_emit_last) begin
                        n_cnt   = '0;
                        n_state = pccr_pkg::S_LOAD;
                    end else begin
                        n_e     = r_e + 1'b1;
                        n_state = pccr_pkg::S_ERD;
                    end
                end
            end
            default: n_state = pccr_pkg::S_LOAD;
        endcase
    end

    // command and handshake outputs
    always_comb begin
        o_cmd.op    = pccr_pkg::OP_NONE;
        o_cmd.sub   = r_sub;
        o_addr      = r_i;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            pccr_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                o_addr     = r_cnt[AW-1:0];
                if (i_in_valid && !w_full) o_cmd.op = pccr_pkg::OP_LOAD;
            end
            pccr_pkg::S_RDA:  o_cmd.op = pccr_pkg::OP_RD;
            pccr_pkg::S_LATA: o_cmd.op = pccr_pkg::OP_LATA;
            pccr_pkg::S_RDB: begin
                o_cmd.op = pccr_pkg::OP_RD;
                o_addr   = r_j;
            end
            pccr_pkg::S_LATB: o_cmd.op = pccr_pkg::OP_LATB;
            pccr_pkg::S_DIFF: o_cmd.op = pccr_pkg::OP_DIFF;
            pccr_pkg::S_SQX:  o_cmd.op = pccr_pkg::OP_SQX;
            pccr_pkg::S_SQY:  o_cmd.op = pccr_pkg::OP_SQY;
            pccr_pkg::S_MSQ:  o_cmd.op = pccr_pkg::OP_MSQ;
            pccr_pkg::S_CMP:  o_cmd.op = pccr_pkg::OP_CMP;
            pccr_pkg::S_SQGO: o_cmd.op = pccr_pkg::OP_SQ_GO;
            pccr_pkg::S_OVL:  o_cmd.op = pccr_pkg::OP_OVL;
            pccr_pkg::S_SMUL: o_cmd.op = pccr_pkg::OP_SMUL;
            pccr_pkg::S_SDGO: o_cmd.op = pccr_pkg::OP_SDIV_GO;
            pccr_pkg::S_SAPP: o_cmd.op = pccr_pkg::OP_SAPP;
            pccr_pkg::S_DMUL: o_cmd.op = pccr_pkg::OP_DMUL;
            pccr_pkg::S_DDGO: o_cmd.op = pccr_pkg::OP_DDIV_GO;
            pccr_pkg::S_DAPP: o_cmd.op = pccr_pkg::OP_DAPP;
            pccr_pkg::S_VCOM: o_cmd.op = pccr_pkg::OP_VCOM;
            pccr_pkg::S_WRA:  o_cmd.op = pccr_pkg::OP_WRA;
            pccr_pkg::S_WRB: begin
                o_cmd.op = pccr_pkg::OP_WRB;
                o_addr   = r_j;
            end
            pccr_pkg::S_ERD: begin
                o_cmd.op = pccr_pkg::OP_RD;
                o_addr   = r_e;
            end
            pccr_pkg::S_ELD: begin
                o_cmd.op  = pccr_pkg::OP_OUT;
                o_cmd.sub = {1'b0, w_emit_last};
            end
            pccr_pkg::S_EOUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

### tb/sv/pccr_checker.sv
// Watches both streams of the collision resolver, predicts each frame and compares results.
`timescale 1ns / 1ps
module pccr_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [pccr_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tuser,
    input  logic                               i_s_tlast,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [pccr_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    input  logic                               i_m_tuser,
    input  logic                               i_m_tlast,
    output int                                 o_errors,
    output int                                 o_waiting,
    output int                                 o_results
);
    localparam int FRAME_DEPTH = pccr_pkg::MAX_ENTITIES_DEF;
    localparam int POS_W       = pccr_pkg::POS_W;
    localparam int RAD_W       = pccr_pkg::RAD_W;
    localparam int CNT_W       = pccr_pkg::CNT_W;

    typedef struct {
        longint     px;
        longint     py;
        longint     vx;
        longint     vy;
        logic       hit;
        int         contacts;
        logic       last;
    } t_resolved;

    t_resolved resolved_q[$];

    longint    frame_x   [FRAME_DEPTH];
    longint    frame_y   [FRAME_DEPTH];
    longint    frame_vx  [FRAME_DEPTH];
    longint    frame_vy  [FRAME_DEPTH];
    longint    frame_rad [FRAME_DEPTH];
    logic      frame_veh [FRAME_DEPTH];
    int        frame_hits[FRAME_DEPTH];
    int        bodies_held;

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= res + bit_w) begin
                n = n - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // scale by 0.9, truncating toward zero
    function automatic longint damp_vel(input longint v);
        longint p;
        p = v * 9;
        return (p < 0) ? -((-p) / 10) : p / 10;
    endfunction

    function automatic longint push_share(input longint d, input longint ovl,
                                          input longint span);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = (mag * ovl) / (2 * span);
        return (d < 0) ? -q : q;
    endfunction

    task automatic resolve_pair(input int i, input int j);
        longint dx, dy, d2, m, span, ovl, sx, sy, tx, ty;
        dx = frame_x[j] - frame_x[i];
        dy = frame_y[j] - frame_y[i];
        d2 = dx * dx + dy * dy;
        m = frame_rad[i] + frame_rad[j];
        if (d2 >= m * m) return;
        if (frame_hits[i] < 63) frame_hits[i]++;
        if (frame_hits[j] < 63) frame_hits[j]++;
        // coincident bodies have no normal: count them but leave them in place
        if (d2 != 0) begin
            span = longint'(int_sqrt(d2));
            ovl = m - span;
            sx = push_share(dx, ovl, span);
            sy = push_share(dy, ovl, span);
            frame_x[i] = clamp24(frame_x[i] - sx);
            frame_y[i] = clamp24(frame_y[i] - sy);
            frame_x[j] = clamp24(frame_x[j] + sx);
            frame_y[j] = clamp24(frame_y[j] + sy);
        end
        if (frame_veh[i] && frame_veh[j]) begin
            tx = frame_vx[i];
            ty = frame_vy[i];
            frame_vx[i] = damp_vel(frame_vx[j]);
            frame_vy[i] = damp_vel(frame_vy[j]);
            frame_vx[j] = damp_vel(tx);
            frame_vy[j] = damp_vel(ty);
        end
    endtask

    task automatic resolve_frame();
        t_resolved r;
        for (int i = 0; i < bodies_held; i++)
            for (int j = i + 1; j < bodies_held; j++)
                resolve_pair(i, j);
        for (int i = 0; i < bodies_held; i++) begin
            r.px = frame_x[i];
            r.py = frame_y[i];
            r.vx = frame_vx[i];
            r.vy = frame_vy[i];
            r.hit = (frame_hits[i] != 0);
            r.contacts = frame_hits[i];
            r.last = (i == bodies_held - 1);
            resolved_q = {resolved_q, r};
        end
        bodies_held = 0;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_errors++;
        end
    endtask

    task automatic check_result();
        t_resolved r;
        logic signed [POS_W-1:0] f;
        if (resolved_q.size() == 0) begin
            $error("unexpected result request: nothing predicted");
            o_errors++;
            return;
        end
        r = resolved_q.pop_front();
        f = i_m_tdata[POS_W-1:0];
        check_field("out_pos_x", r.px, longint'(f));
        f = i_m_tdata[2*POS_W-1:POS_W];
        check_field("out_pos_y", r.py, longint'(f));
        f = i_m_tdata[3*POS_W-1:2*POS_W];
        check_field("out_vel_x", r.vx, longint'(f));
        f = i_m_tdata[4*POS_W-1:3*POS_W];
        check_field("out_vel_y", r.vy, longint'(f));
        check_field("contact_count", r.contacts, longint'(i_m_tdata[4*POS_W+CNT_W-1:4*POS_W]));
        check_field("hit", r.hit, longint'(i_m_tuser));
        check_field("last_out", r.last, longint'(i_m_tlast));
        o_results++;
    endtask

    task automatic load_body();
        logic signed [POS_W-1:0] f;
        if (bodies_held < FRAME_DEPTH) begin
            f = i_s_tdata[POS_W-1:0];           frame_x[bodies_held]  = f;
            f = i_s_tdata[2*POS_W-1:POS_W];     frame_y[bodies_held]  = f;
            f = i_s_tdata[3*POS_W-1:2*POS_W];   frame_vx[bodies_held] = f;
            f = i_s_tdata[4*POS_W-1:3*POS_W];   frame_vy[bodies_held] = f;
            frame_rad[bodies_held]  = i_s_tdata[4*POS_W+RAD_W-1:4*POS_W];
            frame_veh[bodies_held]  = i_s_tuser;
            frame_hits[bodies_held] = 0;
            bodies_held++;
        end
        // a full store drops the body, but tlast still starts the sweep
        if (i_s_tlast) resolve_frame();
    endtask

    initial begin
        o_errors = 0;
        o_results = 0;
        o_waiting = 0;
        bodies_held = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bodies_held = 0;
            resolved_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_s_tvalid && i_s_tready) load_body();
        end
        o_waiting = resolved_q.size();
    end

endmodule

### tb/sv/tb_pairwise_circle_collision_resolve_unit.sv
// Stimulus, flow control and verdict for the circle collision resolver.
`timescale 1ns / 1ps
module tb_pairwise_circle_collision_resolve_unit;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam int     BODY_TARGET = 500;
    localparam int     FRAME_MAX   = pccr_pkg::MAX_ENTITIES_DEF;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    // pos_x, pos_y, vel_x, vel_y, radius (lowest bits first)
    logic [pccr_pkg::IN_DATA_W-1:0]      s_axis_tdata;
    // is_vehicle
    logic                                s_axis_tuser;
    logic                                s_axis_tlast;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    // out_pos_x, out_pos_y, out_vel_x, out_vel_y, contact_count, zero pad
    logic [pccr_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    // hit
    logic                                m_axis_tuser;
    logic                                m_axis_tlast;

    int     mismatches;
    int     pending;
    int     results_seen;
    int     bodies_sent;
    int     frames_sent;
    int     burst_left;
    longint cycles;
    bit     holdoff_done;

    pairwise_circle_collision_resolve_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    pccr_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_m_tlast  (m_axis_tlast),
        .o_errors   (mismatches),
        .o_waiting  (pending),
        .o_results  (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: switch among four stall patterns at random, and once hold off for a
    // long stretch while a result is offered, so the block backs up.
    int rx_phase;
    int rx_mode;
    int rx_hold;
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (!holdoff_done && cycles > 20000 && m_axis_tvalid) begin
            holdoff_done <= 1'b1;
            rx_hold <= 3000;
            m_axis_tready <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (rx_phase % 256 == 0) rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (rx_phase % 5 == 0);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Offer one body and hold it until accepted; gaps fall between bursts.
    task automatic send_body(input logic [23:0] px, input logic [23:0] py,
                             input logic [23:0] vx, input logic [23:0] vy,
                             input logic [15:0] rad, input logic veh, input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rad, vy, vx, py, px};
        s_axis_tuser  <= veh;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bodies_sent++;
        if (last) frames_sent++;
    endtask

    function automatic logic [23:0] near(input logic [23:0] c, input int spread);
        return c + 24'($urandom_range(0, 2 * spread)) - 24'(spread);
    endfunction

    // Bodies clustered so most frames collide; a few are pure noise.
    task automatic random_frame(input int n);
        logic [23:0] cx, cy;
        int spread;
        cx = 24'($urandom);
        cy = 24'($urandom);
        spread = $urandom_range(0, 3) == 0 ? 64 : 1500;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_body(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          16'($urandom), 1'($urandom_range(0, 1)), k == n - 1);
            else
                send_body(near(cx, spread), near(cy, spread), 24'($urandom), 24'($urandom),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 1200)),
                          1'($urandom_range(0, 1)), k == n - 1);
        end
    endtask

    initial begin
        cycles = 0;
        holdoff_done = 1'b0;
        rx_phase = 0;
        rx_mode = 0;
        rx_hold = 0;
        burst_left = 0;
        bodies_sent = 0;
        frames_sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // overlapping vehicles with extreme velocities: swap and damp
        send_body(24'h000000, 24'h000000, 24'h7FFFFF, 24'h800000, 16'h0200, 1'b1, 1'b0);
        send_body(24'h000100, 24'h000080, 24'h800000, 24'h7FFFFF, 16'h0200, 1'b1, 1'b1);
        // coincident vehicles: counted, not moved, velocities still exchanged
        send_body(24'h123456, 24'hFEDCBA, 24'h000123, 24'hFFF000, 16'h0100, 1'b1, 1'b0);
        send_body(24'h123456, 24'hFEDCBA, 24'hFFFF01, 24'h000777, 16'h0100, 1'b1, 1'b1);
        // lone body: nothing to pair with
        send_body(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000001, 16'hFFFF, 1'b0, 1'b1);
        // pushes past both position extremes saturate
        send_body(24'h7FFF00, 24'h7FFFFF, 24'h000000, 24'h000000, 16'hFFFF, 1'b0, 1'b0);
        send_body(24'h7FFFFF, 24'h7FFFF0, 24'h000000, 24'h000000, 16'hFFFF, 1'b0, 1'b1);
        send_body(24'h800000, 24'h800010, 24'h000000, 24'h000000, 16'hFFFF, 1'b1, 1'b0);
        send_body(24'h800100, 24'h800000, 24'h000000, 24'h000000, 16'hFFFF, 1'b1, 1'b1);
        // zero and tiny radii never touch: no pair is closer than its radius sum
        send_body(24'h000000, 24'h000000, 24'h000010, 24'h000020, 16'h0000, 1'b0, 1'b0);
        send_body(24'h000001, 24'h000000, 24'h000030, 24'h000040, 16'h0000, 1'b0, 1'b0);
        send_body(24'h000000, 24'h000001, 24'h000050, 24'h000060, 16'h0001, 1'b1, 1'b1);
        // chain of three, each pair sees earlier updates
        send_body(24'h000000, 24'h000000, 24'h000100, 24'h000000, 16'h0300, 1'b1, 1'b0);
        send_body(24'h000400, 24'h000000, 24'h000000, 24'h000100, 16'h0300, 1'b0, 1'b0);
        send_body(24'h000800, 24'h000100, 24'hFFFF00, 24'h000000, 16'h0300, 1'b1, 1'b1);

        while (bodies_sent < BODY_TARGET) begin
            // once: a frame past capacity, all coincident, so contacts peak
            // at 63 and the extra bodies are dropped
            if (frames_sent == 40) begin
                for (int k = 0; k < FRAME_MAX + 2; k++)
                    send_body(24'h001000, 24'hFFF000, 24'($urandom), 24'($urandom),
                              16'h0040, 1'b0, k == FRAME_MAX + 1);
            end else begin
                random_frame($urandom_range(1, 6));
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;

        // let the checker take in the closing body before watching its backlog
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("run covered %0d bodies in %0d frames, %0d results checked",
                 bodies_sent, frames_sent, results_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
